// ----- design/windowed_sum_squares_flatline_defines.svh -----
// Assertion macros for the checker of the windowed sum-of-squares block.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef WINDOWED_SUM_SQUARES_FLATLINE_DEFINES_SVH
`define WINDOWED_SUM_SQUARES_FLATLINE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define WSSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define WSSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define WSSF_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wssf_pkg.sv -----
// Package for the windowed sum-of-squares block: widths, register indexes, reset values and lane control.
// No dependencies; used by every module of the block.
`default_nettype none

package wssf_pkg;

  localparam int ADC_BITS       = 12;
  localparam int CODE_W         = ADC_BITS;
  localparam int SQ_W           = 2 * ADC_BITS;
  localparam int ACC_W          = 37;
  localparam int OUT_W          = 36;
  localparam int LEN_W          = 13;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;
  localparam int MAX_WINDOW_DEF = 4096;

  localparam logic [CODE_W-1:0] VOLTAGE_OFFSET_RST = CODE_W'(2084);
  localparam logic [CODE_W-1:0] CURRENT_OFFSET_RST = CODE_W'(2048);
  localparam logic [CODE_W-1:0] FLAT_THRESHOLD_RST = CODE_W'(150);
  localparam logic [LEN_W-1:0]  FLAT_LIMIT_RST     = LEN_W'(480);
  localparam logic [LEN_W-1:0]  WINDOW_LEN_RST     = LEN_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_OFFSET = 3'd0,
    REG_CURRENT_OFFSET = 3'd1,
    REG_FLAT_THRESHOLD = 3'd2,
    REG_FLAT_LIMIT     = 3'd3,
    REG_WINDOW_LEN     = 3'd4
  } cfg_reg_t;

  // Control from the window unit to both lanes.
  typedef struct packed {
    logic load;     // a new word enters the squaring stage
    logic advance;  // the squared word is folded into the accumulator
    logic clear;    // that word closes the window
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- design/wssf_lane.sv -----
// One channel lane: offset removal, squaring stage and saturating accumulator.
// Depends on wssf_pkg.
`default_nettype none

module wssf_lane (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [wssf_pkg::CODE_W-1:0] code,
  input  wire logic [wssf_pkg::CODE_W-1:0] offset,
  input  wire wssf_pkg::lane_ctl_t         ctl,
  output logic      [wssf_pkg::ACC_W-1:0]  sum
);

  logic [wssf_pkg::CODE_W-1:0] diff;
  logic [wssf_pkg::SQ_W-1:0]   square;
  logic [wssf_pkg::SQ_W-1:0]   sq;
  logic [wssf_pkg::ACC_W-1:0]  acc;
  logic [wssf_pkg::ACC_W:0]    sum_wide;

  always_comb begin
    diff   = (code >= offset) ? (code - offset) : (offset - code);
    square = wssf_pkg::SQ_W'(diff) * wssf_pkg::SQ_W'(diff);
  end

  // The running sum including the word in the squaring stage, held at full scale.
  always_comb begin
    sum_wide = {1'b0, acc} + (wssf_pkg::ACC_W + 1)'(sq);
    sum      = sum_wide[wssf_pkg::ACC_W] ? '1 : sum_wide[wssf_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sq <= square;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.advance) begin
      acc <= ctl.clear ? '0 : sum;
    end
  end

endmodule

`default_nettype wire

// ----- design/wssf_window.sv -----
// Window control and merge: flow control, sample and flat counters, result register.
// Depends on wssf_pkg; combines the sums of the two wssf_lane instances.
`default_nettype none

module wssf_window #(
  parameter int MAX_WINDOW = wssf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [wssf_pkg::CODE_W-1:0] voltage_code,
  input  wire logic [wssf_pkg::CODE_W-1:0] flat_threshold,
  input  wire logic [wssf_pkg::LEN_W-1:0]  flat_limit,
  input  wire logic [wssf_pkg::LEN_W-1:0]  window_len,
  output wssf_pkg::lane_ctl_t              ctl,
  input  wire logic [wssf_pkg::ACC_W-1:0]  voltage_sum,
  input  wire logic [wssf_pkg::ACC_W-1:0]  current_sum,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [wssf_pkg::OUT_W-1:0]  voltage_sum_sq,
  output logic      [wssf_pkg::OUT_W-1:0]  current_sum_sq,
  output logic                             flatlined
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = ((CNT_W > wssf_pkg::LEN_W) ? CNT_W : wssf_pkg::LEN_W) + 1;

  logic                       s1_valid;
  logic                       s1_flat;
  logic [CNT_W-1:0]           sample_count;
  logic [wssf_pkg::LEN_W-1:0] flat_count;
  logic [wssf_pkg::LEN_W-1:0] flat_count_next;
  logic [CMP_W-1:0]           count_inc;
  logic [CMP_W-1:0]           win;
  logic                       s1_last;
  logic                       out_free;
  logic                       s2_go;
  logic                       s1_ready;
  logic                       is_flat;

  always_comb begin
    if (window_len == '0) begin
      win = CMP_W'(1);
    end else if (CMP_W'(window_len) > CMP_W'(MAX_WINDOW)) begin
      win = CMP_W'(MAX_WINDOW);
    end else begin
      win = CMP_W'(window_len);
    end
    count_inc = CMP_W'(sample_count) + CMP_W'(1);
    s1_last   = (count_inc >= win);

    flat_count_next = (s1_flat && (flat_count != '1)) ? (flat_count + 1'b1) : flat_count;
    is_flat         = (flat_count_next >= flat_limit);

    // A word that closes a window waits only if the result register is still occupied and stalled.
    out_free = !out_valid || !out_stall;
    s2_go    = s1_valid && (!s1_last || out_free);
    s1_ready = !s1_valid || s2_go;
    in_stall = !s1_ready;

    ctl.load    = in_valid && s1_ready;
    ctl.advance = s2_go;
    ctl.clear   = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s1_flat <= (voltage_code <= flat_threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      flat_count   <= '0;
    end else if (s2_go) begin
      if (s1_last) begin
        sample_count <= '0;
        flat_count   <= '0;
      end else begin
        sample_count <= count_inc[CNT_W-1:0];
        flat_count   <= flat_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s1_last) begin
      flatlined <= is_flat;
      if (is_flat) begin
        voltage_sum_sq <= '0;
        current_sum_sq <= '0;
      end else begin
        voltage_sum_sq <= (|voltage_sum[wssf_pkg::ACC_W-1:wssf_pkg::OUT_W]) ?
                          '1 : voltage_sum[wssf_pkg::OUT_W-1:0];
        current_sum_sq <= (|current_sum[wssf_pkg::ACC_W-1:wssf_pkg::OUT_W]) ?
                          '1 : current_sum[wssf_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/windowed_sum_squares_flatline.sv -----
// Top level of the windowed sum-of-squares block with flatline detection.
// Depends on wssf_pkg, wssf_lane and wssf_window.
//
//   Channel   Handshake            Word
//   cfg       cfg_we               cfg_index, cfg_data
//   in        in_valid / in_stall  voltage_code, current_code
//   out       out_valid / out_stall voltage_sum_sq, current_sum_sq, flatlined
//
// One sample word is taken every cycle while in_stall is low; a word goes through the
// squaring stage, then the accumulate stage, which also registers the window result.
// The two lanes square and accumulate side by side; one 12x12 multiply per lane sets
// the stage length. Reset clears the counters, accumulators and valid flags and loads
// the register defaults. Input stalls only while a word that closes a window meets a
// result that is still waiting on out_stall.
`default_nettype none

module windowed_sum_squares_flatline #(
  parameter int MAX_WINDOW = wssf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wssf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wssf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [wssf_pkg::CODE_W-1:0]     voltage_code,
  input  wire logic [wssf_pkg::CODE_W-1:0]     current_code,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [wssf_pkg::OUT_W-1:0]      voltage_sum_sq,
  output logic      [wssf_pkg::OUT_W-1:0]      current_sum_sq,
  output logic                                 flatlined
);

  logic [wssf_pkg::CODE_W-1:0] voltage_offset;
  logic [wssf_pkg::CODE_W-1:0] current_offset;
  logic [wssf_pkg::CODE_W-1:0] flat_threshold;
  logic [wssf_pkg::LEN_W-1:0]  flat_limit;
  logic [wssf_pkg::LEN_W-1:0]  window_len;
  wssf_pkg::lane_ctl_t         ctl;
  logic [wssf_pkg::ACC_W-1:0]  voltage_sum;
  logic [wssf_pkg::ACC_W-1:0]  current_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_offset <= wssf_pkg::VOLTAGE_OFFSET_RST;
      current_offset <= wssf_pkg::CURRENT_OFFSET_RST;
      flat_threshold <= wssf_pkg::FLAT_THRESHOLD_RST;
      flat_limit     <= wssf_pkg::FLAT_LIMIT_RST;
      window_len     <= wssf_pkg::WINDOW_LEN_RST;
    end else if (cfg_we) begin
      case (wssf_pkg::cfg_reg_t'(cfg_index))
        wssf_pkg::REG_VOLTAGE_OFFSET: voltage_offset <= cfg_data[wssf_pkg::CODE_W-1:0];
        wssf_pkg::REG_CURRENT_OFFSET: current_offset <= cfg_data[wssf_pkg::CODE_W-1:0];
        wssf_pkg::REG_FLAT_THRESHOLD: flat_threshold <= cfg_data[wssf_pkg::CODE_W-1:0];
        wssf_pkg::REG_FLAT_LIMIT:     flat_limit     <= cfg_data[wssf_pkg::LEN_W-1:0];
        wssf_pkg::REG_WINDOW_LEN:     window_len     <= cfg_data[wssf_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wssf_lane u_voltage_lane (
    .clk    (clk),
    .rst    (rst),
    .code   (voltage_code),
    .offset (voltage_offset),
    .ctl    (ctl),
    .sum    (voltage_sum)
  );

  wssf_lane u_current_lane (
    .clk    (clk),
    .rst    (rst),
    .code   (current_code),
    .offset (current_offset),
    .ctl    (ctl),
    .sum    (current_sum)
  );

  wssf_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .voltage_code   (voltage_code),
    .flat_threshold (flat_threshold),
    .flat_limit     (flat_limit),
    .window_len     (window_len),
    .ctl            (ctl),
    .voltage_sum    (voltage_sum),
    .current_sum    (current_sum),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .voltage_sum_sq (voltage_sum_sq),
    .current_sum_sq (current_sum_sq),
    .flatlined      (flatlined)
  );

endmodule

`default_nettype wire

// ----- design/wssf_checker.sv -----
// Port-level checks for the windowed sum-of-squares block, bound to its top level.
// Depends on wssf_pkg and windowed_sum_squares_flatline_defines.svh.
`default_nettype none

`include "windowed_sum_squares_flatline_defines.svh"

module wssf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [wssf_pkg::OUT_W-1:0]      voltage_sum_sq,
  input wire logic [wssf_pkg::OUT_W-1:0]      current_sum_sq,
  input wire logic                            flatlined
);

  logic [2*wssf_pkg::OUT_W-1:0] sums;
  logic [2*wssf_pkg::OUT_W+1:0] out_word;

  assign sums     = {voltage_sum_sq, current_sum_sq};
  assign out_word = {out_valid, sums, flatlined};

  // A stalled result word keeps its place and its contents.
  `WSSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_word), "held word changed")

  // A flatlined window never reports sums.
  `WSSF_ASSERT_NOW(a_flat_zero, out_valid && flatlined, sums == '0, "flatlined word has sums")

  // No result can be pending in the cycle after reset.
  `WSSF_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "result valid right after reset")

  // With no result waiting, the input side is always open.
  `WSSF_ASSERT_NOW(a_in_open, !out_valid, !in_stall, "input stalled with no result pending")

endmodule

bind windowed_sum_squares_flatline wssf_checker u_wssf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .voltage_sum_sq (voltage_sum_sq),
  .current_sum_sq (current_sum_sq),
  .flatlined      (flatlined)
);

`default_nettype wire
